@@ design/swq_pkg.sv @@
// Shared constants, codes and beat types for the semaphore table with wait queues.
package swq_pkg;

    localparam int SEM_COUNT   = 16;
    localparam int QUEUE_DEPTH = 8;
    localparam int PID_WIDTH   = 8;
    localparam int COUNT_WIDTH = 16;

    localparam int ID_W      = 32;
    localparam int INIT_W    = 16;
    localparam int PID_PORTW = 8;

    localparam int SEM_IW    = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = SEM_COUNT * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [1:0] {
        REQ_OPEN  = 2'd0,
        REQ_WAIT  = 2'd1,
        REQ_POST  = 2'd2,
        REQ_CLOSE = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_QUEUE_FULL = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type             req_type;
        logic [ID_W-1:0]       sem_id;
        logic [INIT_W-1:0]     init_count;
        logic [PID_PORTW-1:0]  caller_pid;
    } t_req;

    typedef struct packed {
        t_status status;
        logic    caller_blocks;
        logic    wake_valid;
    } t_res;

endpackage

@@ design/swq_engine.sv @@
// Semaphore table, per-entry queue pointers and waiter memory; one request per cycle while i_en is high.
module swq_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  swq_pkg::t_req               i_req,
    output swq_pkg::t_res               o_res,
    output logic [swq_pkg::PID_WIDTH-1:0] o_wake_pid
);

    localparam int SEM_COUNT   = swq_pkg::SEM_COUNT;
    localparam int QUEUE_DEPTH = swq_pkg::QUEUE_DEPTH;
    localparam int SEM_IW      = swq_pkg::SEM_IW;
    localparam int QPTR_W      = swq_pkg::QPTR_W;
    localparam int FILL_W      = swq_pkg::FILL_W;
    localparam int ADDR_W      = swq_pkg::ADDR_W;
    localparam int COUNT_WIDTH = swq_pkg::COUNT_WIDTH;
    localparam int PID_WIDTH   = swq_pkg::PID_WIDTH;

    logic [SEM_COUNT-1:0]   r_valid;
    logic [swq_pkg::ID_W-1:0] r_id    [SEM_COUNT];
    logic [COUNT_WIDTH-1:0] r_count [SEM_COUNT];
    logic [QPTR_W-1:0]      r_head  [SEM_COUNT];
    logic [FILL_W-1:0]      r_fill  [SEM_COUNT];
    logic [PID_WIDTH-1:0]   r_mem   [swq_pkg::MEM_DEPTH];
    logic [PID_WIDTH-1:0]   r_rd_pid;

    logic                   w_hit;
    logic [SEM_IW-1:0]      w_hit_idx;
    logic                   w_free;
    logic [SEM_IW-1:0]      w_free_idx;
    logic [COUNT_WIDTH-1:0] w_cnt;
    logic [QPTR_W-1:0]      w_head;
    logic [FILL_W-1:0]      w_fill;
    logic [FILL_W:0]        w_tail_sum;
    logic [FILL_W:0]        w_head_sum;
    logic [QPTR_W-1:0]      w_tail;
    logic [QPTR_W-1:0]      w_head_nx;
    logic [ADDR_W-1:0]      w_base;
    logic [COUNT_WIDTH-1:0] w_init;
    logic [PID_WIDTH-1:0]   w_pid;

    // lowest matching entry and lowest free entry
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_free     = 1'b0;
        w_free_idx = '0;
        for (int i = SEM_COUNT - 1; i >= 0; i--) begin
            if (r_valid[i] && r_id[i] == i_req.sem_id) begin
                w_hit     = 1'b1;
                w_hit_idx = SEM_IW'(i);
            end
            if (!r_valid[i]) begin
                w_free     = 1'b1;
                w_free_idx = SEM_IW'(i);
            end
        end
    end

    assign w_cnt  = r_count[w_hit_idx];
    assign w_head = r_head[w_hit_idx];
    assign w_fill = r_fill[w_hit_idx];
    assign w_init = COUNT_WIDTH'(i_req.init_count);
    assign w_pid  = PID_WIDTH'(i_req.caller_pid);

    // wrap tail and next head without a divider; sums stay below twice the depth
    assign w_tail_sum = (FILL_W + 1)'(w_head) + (FILL_W + 1)'(w_fill);
    assign w_head_sum = (FILL_W + 1)'(w_head) + (FILL_W + 1)'(1);
    assign w_tail     = (w_tail_sum >= (FILL_W + 1)'(QUEUE_DEPTH))
                        ? QPTR_W'(w_tail_sum - (FILL_W + 1)'(QUEUE_DEPTH))
                        : QPTR_W'(w_tail_sum);
    assign w_head_nx  = (w_head_sum >= (FILL_W + 1)'(QUEUE_DEPTH))
                        ? QPTR_W'(w_head_sum - (FILL_W + 1)'(QUEUE_DEPTH))
                        : QPTR_W'(w_head_sum);
    assign w_base     = ADDR_W'(w_hit_idx) * ADDR_W'(QUEUE_DEPTH);

    logic w_create;
    logic w_take;
    logic w_enqueue;
    logic w_dequeue;
    logic w_incr;
    logic w_close;

    always_comb begin
        o_res        = '{status: swq_pkg::ST_OK, caller_blocks: 1'b0, wake_valid: 1'b0};
        w_create     = 1'b0;
        w_take       = 1'b0;
        w_enqueue    = 1'b0;
        w_dequeue    = 1'b0;
        w_incr       = 1'b0;
        w_close      = 1'b0;
        if (i_req.req_type == swq_pkg::REQ_OPEN) begin
            if (!w_hit) begin
                if (w_free) begin
                    w_create = 1'b1;
                end else begin
                    o_res.status = swq_pkg::ST_TABLE_FULL;
                end
            end
        end else if (!w_hit) begin
            o_res.status = swq_pkg::ST_NOT_FOUND;
        end else begin
            case (i_req.req_type)
                swq_pkg::REQ_WAIT: begin
                    if (w_cnt != '0) begin
                        w_take = 1'b1;
                    end else if (w_fill >= FILL_W'(QUEUE_DEPTH)) begin
                        o_res.status = swq_pkg::ST_QUEUE_FULL;
                    end else begin
                        w_enqueue           = 1'b1;
                        o_res.caller_blocks = 1'b1;
                    end
                end
                swq_pkg::REQ_POST: begin
                    if (w_fill != '0) begin
                        w_dequeue        = 1'b1;
                        o_res.wake_valid = 1'b1;
                    end else begin
                        // saturate at the top count
                        w_incr = (w_cnt != '1);
                    end
                end
                swq_pkg::REQ_CLOSE: begin
                    w_close = 1'b1;
                end
                default: begin
                    w_close = 1'b0;
                end
            endcase
        end
    end

    // control state: valid bits and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < SEM_COUNT; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (i_en) begin
            if (w_create) begin
                r_valid[w_free_idx] <= 1'b1;
                r_head[w_free_idx]  <= '0;
                r_fill[w_free_idx]  <= '0;
            end
            if (w_close) begin
                r_valid[w_hit_idx] <= 1'b0;
                r_head[w_hit_idx]  <= '0;
                r_fill[w_hit_idx]  <= '0;
            end
            if (w_enqueue) begin
                r_fill[w_hit_idx] <= w_fill + FILL_W'(1);
            end
            if (w_dequeue) begin
                r_head[w_hit_idx] <= w_head_nx;
                r_fill[w_hit_idx] <= w_fill - FILL_W'(1);
            end
        end
    end

    // payload: ids and counts
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_create) begin
                r_id[w_free_idx]    <= i_req.sem_id;
                r_count[w_free_idx] <= w_init;
            end
            if (w_take) begin
                r_count[w_hit_idx] <= w_cnt - COUNT_WIDTH'(1);
            end
            if (w_incr) begin
                r_count[w_hit_idx] <= w_cnt + COUNT_WIDTH'(1);
            end
        end
    end

    // waiter memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_en && w_enqueue) begin
            r_mem[w_base + ADDR_W'(w_tail)] <= w_pid;
        end
        if (i_en && w_dequeue) begin
            r_rd_pid <= r_mem[w_base + ADDR_W'(w_head)];
        end
    end

    assign o_wake_pid = r_rd_pid;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && w_enqueue |=> r_fill[$past(w_hit_idx)] <= FILL_W'(QUEUE_DEPTH))
        else $error("wait queue fill beyond depth");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_res.caller_blocks && o_res.wake_valid))
        else $error("block and wake in one result");

    a_create_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && w_create |-> !r_valid[w_free_idx] && !w_hit)
        else $error("open overwrote a live entry");

    a_wake_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.wake_valid |=> r_fill[$past(w_hit_idx)] == $past(w_fill) - FILL_W'(1))
        else $error("wake without queue advance");

endmodule

@@ design/semaphore_table_with_wait_queues.sv @@
// Top level: stream channels, input register and result register around the table engine.
//
// Requests arrive on the s_axis channel: tuser carries the request type (open, wait,
// post, close), tdata carries sem_id, init_count and caller_pid. Every request gives
// exactly one result beat on m_axis: tuser carries status, caller_blocks and
// wake_valid; tdata carries wake_pid (zero unless wake_valid).
// The accepting edge loads the input register; the table lookup and update that follow
// land in the result register when that is free or drained. Throughput is one request
// per cycle while m_axis does not stall; the id match over the whole table and one queue
// update are done combinationally between the two registers, and the waiter pid comes
// from the queue memory's registered read port.
// At reset the table is empty and all queues are cleared at once; requests are taken
// from the first cycle after reset.
// When m_axis stalls, the result register holds, the engine stops, and the input
// register fills; s_axis_tready drops once both are occupied.
module semaphore_table_with_wait_queues (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // sem_id[31:0], init_count[47:32], caller_pid[55:48]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // wake_pid[7:0]
    output logic [3:0]  m_axis_tuser    // status[1:0], caller_blocks[2], wake_valid[3]
);

    logic            r_in_valid;
    swq_pkg::t_req   r_in;
    logic            r_out_valid;
    swq_pkg::t_res   r_out;
    swq_pkg::t_res   w_res;
    logic [swq_pkg::PID_WIDTH-1:0] w_wake_pid;
    logic            w_adv;

    // advance the engine when the result register is free or being drained
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.req_type   <= swq_pkg::t_req_type'(s_axis_tuser);
            r_in.sem_id     <= s_axis_tdata[31:0];
            r_in.init_count <= s_axis_tdata[47:32];
            r_in.caller_pid <= s_axis_tdata[55:48];
        end
    end

    swq_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_req      (r_in),
        .o_res      (w_res),
        .o_wake_pid (w_wake_pid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.wake_valid, r_out.caller_blocks, r_out.status};
    assign m_axis_tdata  = r_out.wake_valid ? 8'(w_wake_pid) : 8'd0;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

    a_adv_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |-> r_in_valid)
        else $error("engine advanced without a request");

    a_blocks_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.caller_blocks || r_out.wake_valid)
            |-> r_out.status == swq_pkg::ST_OK)
        else $error("block or wake with error status");

endmodule

@@ tb/semaphore_table_with_wait_queues_tb.sv @@
// Self-checking stream testbench for the semaphore table with FIFO wait queues.
`timescale 1ns / 1ps

module semaphore_table_with_wait_queues_tb;

    typedef struct packed {
        swq_pkg::t_status status;
        logic             blocks;
        logic             wake;
        logic [7:0]       wake_pid;
    } t_outcome;

    typedef struct {
        swq_pkg::t_req_type op;
        logic [31:0]        key;
        logic [15:0]        init;
        logic [7:0]         pid;
        int                 reps;     // repeat count; waits step the pid, others step the id
        logic               typed;
        t_outcome           res;
    } t_row;

    localparam t_outcome R_OK    = '{swq_pkg::ST_OK, 1'b0, 1'b0, 8'h00};
    localparam t_outcome R_BLOCK = '{swq_pkg::ST_OK, 1'b1, 1'b0, 8'h00};
    localparam t_outcome R_MISS  = '{swq_pkg::ST_NOT_FOUND, 1'b0, 1'b0, 8'h00};
    localparam t_outcome R_QFULL = '{swq_pkg::ST_QUEUE_FULL, 1'b0, 1'b0, 8'h00};
    localparam t_outcome R_TFULL = '{swq_pkg::ST_TABLE_FULL, 1'b0, 1'b0, 8'h00};
    localparam t_outcome R_W_FF  = '{swq_pkg::ST_OK, 1'b0, 1'b1, 8'hFF};
    localparam t_outcome R_W_00  = '{swq_pkg::ST_OK, 1'b0, 1'b1, 8'h00};
    localparam t_outcome R_W_10  = '{swq_pkg::ST_OK, 1'b0, 1'b1, 8'h10};
    localparam int       POOL    = 24;
    localparam int       PHASE_ITEMS = 340;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // sem_id[31:0], init_count[47:32], caller_pid[55:48]
    logic [1:0]  s_axis_tuser  = '0;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // wake_pid[7:0]
    logic [3:0]  m_axis_tuser;         // status[1:0], caller_blocks[2], wake_valid[3]

    // typed expectation travels alongside the request beat
    logic        row_typed = 1'b0;
    t_outcome    row_exp   = R_OK;

    int idle_pct  = 0;
    int stall_pct = 0;
    int n_err     = 0;

    t_outcome expected_results[$];

    // table mirror
    bit                            sem_live   [swq_pkg::SEM_COUNT];
    bit [31:0]                     sem_key    [swq_pkg::SEM_COUNT];
    bit [swq_pkg::COUNT_WIDTH-1:0] sem_count  [swq_pkg::SEM_COUNT];
    bit [swq_pkg::PID_WIDTH-1:0]   sem_waiter [swq_pkg::SEM_COUNT][swq_pkg::QUEUE_DEPTH];
    int                            sem_head   [swq_pkg::SEM_COUNT];
    int                            sem_fill   [swq_pkg::SEM_COUNT];

    int idle_tbl  [4] = '{0, 72, 0, 8};
    int stall_tbl [4] = '{0, 0, 72, 8};

    t_row script [26] = '{
        '{swq_pkg::REQ_WAIT,  32'h0000_0000, 16'h0000, 8'h00, 1,  1'b1, R_MISS},
        '{swq_pkg::REQ_POST,  32'hFFFF_FFFF, 16'h0000, 8'h00, 1,  1'b1, R_MISS},
        '{swq_pkg::REQ_CLOSE, 32'h0000_0000, 16'h0000, 8'h00, 1,  1'b1, R_MISS},
        '{swq_pkg::REQ_OPEN,  32'h0000_0000, 16'h0000, 8'h00, 1,  1'b1, R_OK},
        '{swq_pkg::REQ_OPEN,  32'h0000_0000, 16'h0005, 8'h00, 1,  1'b1, R_OK},
        '{swq_pkg::REQ_WAIT,  32'h0000_0000, 16'h0000, 8'hFF, 1,  1'b1, R_BLOCK},
        '{swq_pkg::REQ_WAIT,  32'h0000_0000, 16'h0000, 8'h00, 1,  1'b1, R_BLOCK},
        '{swq_pkg::REQ_POST,  32'h0000_0000, 16'h0000, 8'h00, 1,  1'b1, R_W_FF},
        '{swq_pkg::REQ_POST,  32'h0000_0000, 16'h0000, 8'h00, 1,  1'b1, R_W_00},
        '{swq_pkg::REQ_POST,  32'h0000_0000, 16'h0000, 8'h00, 1,  1'b1, R_OK},
        '{swq_pkg::REQ_WAIT,  32'h0000_0000, 16'h0000, 8'h5A, 1,  1'b0, R_OK},
        '{swq_pkg::REQ_OPEN,  32'hFFFF_FFFF, 16'hFFFF, 8'h00, 1,  1'b1, R_OK},
        '{swq_pkg::REQ_POST,  32'hFFFF_FFFF, 16'h0000, 8'h00, 1,  1'b1, R_OK},
        '{swq_pkg::REQ_WAIT,  32'hFFFF_FFFF, 16'h0000, 8'hC3, 1,  1'b0, R_OK},
        '{swq_pkg::REQ_CLOSE, 32'hFFFF_FFFF, 16'h0000, 8'h00, 1,  1'b1, R_OK},
        '{swq_pkg::REQ_POST,  32'hFFFF_FFFF, 16'h0000, 8'h00, 1,  1'b1, R_MISS},
        '{swq_pkg::REQ_WAIT,  32'h0000_0000, 16'h0000, 8'h10, 8,  1'b1, R_BLOCK},
        '{swq_pkg::REQ_WAIT,  32'h0000_0000, 16'h0000, 8'hAA, 1,  1'b1, R_QFULL},
        '{swq_pkg::REQ_POST,  32'h0000_0000, 16'h0000, 8'h00, 1,  1'b1, R_W_10},
        '{swq_pkg::REQ_CLOSE, 32'h0000_0000, 16'h0000, 8'h00, 1,  1'b1, R_OK},
        '{swq_pkg::REQ_OPEN,  32'h0000_0000, 16'h0000, 8'h00, 1,  1'b1, R_OK},
        '{swq_pkg::REQ_POST,  32'h0000_0000, 16'h0000, 8'h00, 1,  1'b0, R_OK},
        '{swq_pkg::REQ_CLOSE, 32'h0000_0000, 16'h0000, 8'h00, 1,  1'b1, R_OK},
        '{swq_pkg::REQ_OPEN,  32'h0000_0100, 16'h8001, 8'h00, 16, 1'b1, R_OK},
        '{swq_pkg::REQ_OPEN,  32'hDEAD_BEEF, 16'h0001, 8'h00, 1,  1'b1, R_TFULL},
        '{swq_pkg::REQ_CLOSE, 32'h0000_0100, 16'h0000, 8'h00, 16, 1'b1, R_OK}
    };

    semaphore_table_with_wait_queues u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Apply one request to the table mirror and return the result it should give.
    function automatic t_outcome apply_to_table(swq_pkg::t_req_type op, logic [31:0] key,
                                                logic [swq_pkg::COUNT_WIDTH-1:0] init,
                                                logic [swq_pkg::PID_WIDTH-1:0] pid);
        t_outcome r;
        int       hit;
        int       spare;
        r     = R_OK;
        hit   = -1;
        spare = -1;
        // scan downward so the lowest index wins
        for (int i = swq_pkg::SEM_COUNT - 1; i >= 0; i--) begin
            if (sem_live[i] && sem_key[i] == key) hit = i;
            if (!sem_live[i]) spare = i;
        end
        if (op == swq_pkg::REQ_OPEN) begin
            if (hit < 0) begin
                if (spare < 0) begin
                    r.status = swq_pkg::ST_TABLE_FULL;
                end else begin
                    sem_live[spare]  = 1'b1;
                    sem_key[spare]   = key;
                    sem_count[spare] = init;
                    sem_head[spare]  = 0;
                    sem_fill[spare]  = 0;
                end
            end
        end else if (hit < 0) begin
            r.status = swq_pkg::ST_NOT_FOUND;
        end else begin
            case (op)
                swq_pkg::REQ_WAIT: begin
                    if (sem_count[hit] != 0) begin
                        sem_count[hit]--;
                    end else if (sem_fill[hit] >= swq_pkg::QUEUE_DEPTH) begin
                        r.status = swq_pkg::ST_QUEUE_FULL;
                    end else begin
                        sem_waiter[hit][(sem_head[hit] + sem_fill[hit])
                                        % swq_pkg::QUEUE_DEPTH] = pid;
                        sem_fill[hit]++;
                        r.blocks = 1'b1;
                    end
                end
                swq_pkg::REQ_POST: begin
                    if (sem_fill[hit] > 0) begin
                        r.wake     = 1'b1;
                        r.wake_pid = sem_waiter[hit][sem_head[hit]];
                        sem_head[hit] = (sem_head[hit] + 1) % swq_pkg::QUEUE_DEPTH;
                        sem_fill[hit]--;
                    end else if (sem_count[hit] != '1) begin
                        sem_count[hit]++;
                    end
                end
                default: begin
                    sem_live[hit] = 1'b0;
                    sem_head[hit] = 0;
                    sem_fill[hit] = 0;
                end
            endcase
        end
        return r;
    endfunction

    // Present one request beat and hold it until accepted.
    task automatic issue_request(swq_pkg::t_req_type op, logic [31:0] key,
                                 logic [15:0] init, logic [7:0] pid, logic typed,
                                 t_outcome res);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {pid, init, key};
        row_typed     <= typed;
        row_exp       <= res;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Check result beats, predict accepted requests, drive receiver back-pressure.
    always @(posedge i_clk) begin : result_check
        t_outcome got;
        t_outcome want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{swq_pkg::t_status'(m_axis_tuser[1:0]), m_axis_tuser[2],
                    m_axis_tuser[3], m_axis_tdata};
            if (expected_results.size() == 0) begin
                n_err++;
                if (n_err <= 30)
                    $display({"%0t ns: unexpected result beat: expected none, ",
                              "got status %0d blocks %0b wake %0b pid 0x%02h"},
                             $time, got.status, got.blocks, got.wake, got.wake_pid);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 30)
                        $display({"%0t ns: mismatch: expected status %0d blocks %0b wake %0b ",
                                  "pid 0x%02h, got status %0d blocks %0b wake %0b pid 0x%02h"},
                                 $time, want.status, want.blocks, want.wake, want.wake_pid,
                                 got.status, got.blocks, got.wake, got.wake_pid);
                end
            end
        end
        if (s_axis_tvalid && s_axis_tready) begin
            want = apply_to_table(swq_pkg::t_req_type'(s_axis_tuser), s_axis_tdata[31:0],
                                  s_axis_tdata[47:32], s_axis_tdata[55:48]);
            if (row_typed) want = row_exp;
            expected_results.push_back(want);
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin : stimulus
        logic [31:0]        id_pool [POOL];
        swq_pkg::t_req_type op;
        logic [31:0]        key;
        logic [15:0]        init;
        int                 r;
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL; i++) id_pool[i] = $urandom();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[n]) begin
            for (int j = 0; j < script[n].reps; j++) begin
                if (script[n].op == swq_pkg::REQ_WAIT)
                    issue_request(script[n].op, script[n].key, script[n].init,
                                  script[n].pid + 8'(j), script[n].typed, script[n].res);
                else
                    issue_request(script[n].op, script[n].key + 32'(j), script[n].init,
                                  script[n].pid, script[n].typed, script[n].res);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tbl[ph];
            stall_pct = stall_tbl[ph];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r  = $urandom_range(99);
                op = (r < 20) ? swq_pkg::REQ_OPEN : (r < 55) ? swq_pkg::REQ_WAIT :
                     (r < 85) ? swq_pkg::REQ_POST : swq_pkg::REQ_CLOSE;
                // a few hot ids fill queues; stray ids never open, so no entry leaks
                r = $urandom_range(99);
                if (r < 8 && op != swq_pkg::REQ_OPEN) key = $urandom();
                else if (r < 55)                      key = id_pool[$urandom_range(3)];
                else                                  key = id_pool[$urandom_range(POOL - 1)];
                r = $urandom_range(99);
                init = (r < 50) ? 16'h0000 : (r < 75) ? 16'($urandom_range(3)) :
                       (r < 85) ? 16'hFFFF : 16'($urandom());
                issue_request(op, key, init, 8'($urandom()), 1'b0, R_OK);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
